FILE: sv/clsr_pkg.sv
// clsr_pkg: shared types and constants for the combined lcg shuffle generator
// holds moduli, multipliers, fold constants, sequencer and operation codes
// no dependencies
`default_nettype none

package clsr_pkg;

  localparam int VAL_W  = 31;
  localparam int MUL_W  = 16;
  localparam int PROD_W = VAL_W + MUL_W;
  localparam int SUM_W  = 32;

  // generator one: 40014 mod 2^31-85, generator two: 40692 mod 2^31-249
  localparam logic [SUM_W-1:0] MOD_ONE  = 32'd2147483563;
  localparam logic [SUM_W-1:0] MOD_TWO  = 32'd2147483399;
  localparam logic [SUM_W-1:0] SPAN_MAX = 32'd2147483562;
  localparam logic [MUL_W-1:0] MUL_ONE  = 16'd40014;
  localparam logic [MUL_W-1:0] MUL_TWO  = 16'd40692;
  // 2^31 mod m for each modulus
  localparam logic [7:0]       FOLD_ONE = 8'd85;
  localparam logic [7:0]       FOLD_TWO = 8'd249;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SEED = 10'b00_0000_0010,
    ST_MUL  = 10'b00_0000_0100,
    ST_FOLD = 10'b00_0000_1000,
    ST_RED  = 10'b00_0001_0000,
    ST_DIV  = 10'b00_0010_0000,
    ST_READ = 10'b00_0100_0000,
    ST_DIFF = 10'b00_1000_0000,
    ST_ADJ  = 10'b01_0000_0000,
    ST_EMIT = 10'b10_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_WARM = 3'b001,
    OP_ONE  = 3'b010,
    OP_TWO  = 3'b100
  } op_t;

endpackage

`default_nettype wire

FILE: sv/combined_lcg_shuffle_rng.sv
// combined_lcg_shuffle_rng: two multiplicative congruential generators combined
// through a bays-durham shuffle table, one 31-bit number per request beat
// depends on clsr_pkg
`default_nettype none

// One request beat on the s_ side gives one result beat on the m_ side. The
// block is built around a single modular multiply unit (31x16 multiply, fold of
// the high part by 2^31 mod m, one conditional subtract) that runs each
// generator step through the MUL, FOLD and RED states and is shared by both
// generators and by the warm-up. A normal request runs two generator steps,
// the slot pick by comparing the previous number against constant multiples
// of the slot width, a registered table read, the difference and its wrap.
// The first request after reset, and any request with restart set, first
// reseeds from seed_value and runs TABLE_ENTRIES+8 warm-up steps. s_tready is
// high only while the sequencer is idle, so a new request is taken no earlier
// than the cycle after the previous result is posted, and never before the
// last one is finished. A finished result sits in the output register while
// the next request is taken; if it is still unread when the next number is
// ready, the sequencer waits in its last state and s_tready stays low. The
// user must write seed_value over the cfg channel only while no request is in
// flight; the block itself does not enforce this.
module combined_lcg_shuffle_rng #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request beat
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  // result beat
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [30:0] random_value, [31] zero
  // seed register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [30:0] cfg_data   // [30:0] seed_value
);

  localparam int VW = clsr_pkg::VAL_W;
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 8);
  localparam int DW = 33;
  // slot width: 1 + span / entries
  localparam logic [DW-1:0] SLOT_DIV =
    DW'(32'd1 + clsr_pkg::SPAN_MAX / 32'(TABLE_ENTRIES));

  clsr_pkg::state_t st;
  clsr_pkg::op_t    op;

  logic [CW-1:0]               cnt;
  logic [VW-1:0]               seed_value;
  logic [VW-1:0]               first_gen;
  logic [VW-1:0]               second_gen;
  logic [VW-1:0]               last_output;
  logic                        seeded;
  logic [clsr_pkg::PROD_W-1:0] prod;
  logic [clsr_pkg::SUM_W-1:0]  fsum;
  logic [VW-1:0]               rd_data;
  logic signed [DW-1:0]        diff;

  logic [VW-1:0]               shuffle_store [TABLE_ENTRIES];

  // shared modular multiply unit operand selection
  logic [VW-1:0]               mm_opnd;
  logic [clsr_pkg::MUL_W-1:0]  mm_mult;
  logic [7:0]                  mm_fold;
  logic [clsr_pkg::SUM_W-1:0]  mm_mod;
  logic [VW-1:0]               red_res;

  logic [VW-1:0]               seed_red;
  logic                        seed_zero;
  logic [VW-1:0]               seed_eff;

  logic [DW-1:0]               thr;
  logic [IW-1:0]               slot_pick;
  logic [IW-1:0]               slot;

  logic                        mem_we;
  logic [IW-1:0]               mem_wa;
  logic [VW-1:0]               mem_wd;
  logic                        warm_store;
  logic signed [DW-1:0]        adj;
  logic                        emit_go;

  assign s_tready  = (st == clsr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (op == clsr_pkg::OP_TWO) begin
      mm_opnd = second_gen;
      mm_mult = clsr_pkg::MUL_TWO;
      mm_fold = clsr_pkg::FOLD_TWO;
      mm_mod  = clsr_pkg::MOD_TWO;
    end else begin
      mm_opnd = first_gen;
      mm_mult = clsr_pkg::MUL_ONE;
      mm_fold = clsr_pkg::FOLD_ONE;
      mm_mod  = clsr_pkg::MOD_ONE;
    end
  end

  // fsum < 2^31 + 2^24 < 2m, so one subtract finishes the reduction
  assign red_res = (fsum >= mm_mod) ? VW'(fsum - mm_mod) : fsum[VW-1:0];

  // seed reduced mod m1, zero taken as one
  assign seed_red  = ({1'b0, seed_value} >= clsr_pkg::MOD_ONE)
                   ? VW'({1'b0, seed_value} - clsr_pkg::MOD_ONE) : seed_value;
  assign seed_zero = (seed_value == '0) || ({1'b0, seed_value} == clsr_pkg::MOD_ONE);
  assign seed_eff  = seed_zero ? VW'(1) : seed_red;

  // slot = highest k below TABLE_ENTRIES whose k * slot width does not exceed
  // the previous number; this also clamps to the last slot
  always_comb begin
    slot_pick = '0;
    thr       = '0;
    for (int k = 1; k < TABLE_ENTRIES; k++) begin
      thr = DW'(k) * SLOT_DIV;
      if ({{(DW-VW){1'b0}}, last_output} >= thr) begin
        slot_pick = IW'(k);
      end
    end
  end

  // warm-up fills the table on its last TABLE_ENTRIES steps
  assign warm_store = (cnt < CW'(TABLE_ENTRIES));
  assign mem_we = ((st == clsr_pkg::ST_RED) && (op == clsr_pkg::OP_WARM) && warm_store)
               || (st == clsr_pkg::ST_DIFF);
  assign mem_wa = (st == clsr_pkg::ST_DIFF) ? slot : cnt[IW-1:0];
  assign mem_wd = (st == clsr_pkg::ST_DIFF) ? first_gen : red_res;

  assign adj = diff + $signed({1'b0, clsr_pkg::SPAN_MAX});

  // result register free or being read this cycle
  assign emit_go = (st == clsr_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shuffle_store[mem_wa] <= mem_wd;
    end
    if (st == clsr_pkg::ST_READ) begin
      rd_data <= shuffle_store[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= VW'(1);
    end else if (cfg_valid && cfg_ready) begin
      seed_value <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= clsr_pkg::ST_IDLE;
      op          <= clsr_pkg::OP_ONE;
      cnt         <= '0;
      first_gen   <= '0;
      second_gen  <= '0;
      last_output <= '0;
      seeded      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        clsr_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            if (!seeded || s_tdata[0]) begin
              st <= clsr_pkg::ST_SEED;
            end else begin
              op <= clsr_pkg::OP_ONE;
              st <= clsr_pkg::ST_MUL;
            end
          end
        end
        clsr_pkg::ST_SEED: begin
          first_gen  <= seed_eff;
          second_gen <= seed_eff;
          cnt        <= CW'(TABLE_ENTRIES + 7);
          op         <= clsr_pkg::OP_WARM;
          st         <= clsr_pkg::ST_MUL;
        end
        clsr_pkg::ST_MUL: begin
          prod <= {{clsr_pkg::MUL_W{1'b0}}, mm_opnd} *
                  {{VW{1'b0}}, mm_mult};
          st   <= clsr_pkg::ST_FOLD;
        end
        clsr_pkg::ST_FOLD: begin
          // x*a = hi*2^31 + lo, and 2^31 = fold (mod m)
          fsum <= clsr_pkg::SUM_W'(prod[clsr_pkg::PROD_W-1:VW])
                * clsr_pkg::SUM_W'(mm_fold)
                + clsr_pkg::SUM_W'(prod[VW-1:0]);
          st   <= clsr_pkg::ST_RED;
        end
        clsr_pkg::ST_RED: begin
          case (op)
            clsr_pkg::OP_WARM: begin
              first_gen <= red_res;
              if (cnt == '0) begin
                last_output <= red_res;
                seeded      <= 1'b1;
                op          <= clsr_pkg::OP_ONE;
              end else begin
                cnt <= cnt - CW'(1);
              end
              st <= clsr_pkg::ST_MUL;
            end
            clsr_pkg::OP_ONE: begin
              first_gen <= red_res;
              op        <= clsr_pkg::OP_TWO;
              st        <= clsr_pkg::ST_MUL;
            end
            default: begin
              second_gen <= red_res;
              st         <= clsr_pkg::ST_DIV;
            end
          endcase
        end
        clsr_pkg::ST_DIV: begin
          slot <= slot_pick;
          st   <= clsr_pkg::ST_READ;
        end
        clsr_pkg::ST_READ: begin
          st <= clsr_pkg::ST_DIFF;
        end
        clsr_pkg::ST_DIFF: begin
          // slot refilled with generator one in this cycle
          diff <= $signed({2'b00, rd_data}) - $signed({2'b00, second_gen});
          st   <= clsr_pkg::ST_ADJ;
        end
        clsr_pkg::ST_ADJ: begin
          last_output <= (diff < 33'sd1) ? adj[VW-1:0] : diff[VW-1:0];
          st          <= clsr_pkg::ST_EMIT;
        end
        clsr_pkg::ST_EMIT: begin
          if (emit_go) begin
            m_tdata <= {1'b0, last_output};
            st      <= clsr_pkg::ST_IDLE;
          end
        end
        default: begin
          st <= clsr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // no result before the table has been filled
  a_emit_seeded: assert property (@(posedge clk) disable iff (rst)
    (st == clsr_pkg::ST_EMIT) |-> seeded)
    else $error("result pending while unseeded");

  // results stay in the documented range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31] == 1'b0) && (m_tdata[30:0] != '0)
                 && ({1'b0, m_tdata} <= {1'b0, clsr_pkg::SPAN_MAX}))
    else $error("result out of range");

  // both generators fully reduced once the steps are done
  a_gen_reduced: assert property (@(posedge clk) disable iff (rst)
    (st == clsr_pkg::ST_DIV) |-> ({1'b0, first_gen} < clsr_pkg::MOD_ONE)
                                && ({1'b0, second_gen} < clsr_pkg::MOD_TWO))
    else $error("generator state not reduced");

  // an accepted request starts either a reseed or a generator step
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (st == clsr_pkg::ST_SEED)
                               || ((st == clsr_pkg::ST_MUL) && (op == clsr_pkg::OP_ONE)))
    else $error("bad start after request beat");

  // picked slot never starts above the previous number
  a_slot_pick: assert property (@(posedge clk) disable iff (rst)
    (st == clsr_pkg::ST_READ)
      |-> ((DW'(slot) * SLOT_DIV) <= {{(DW-VW){1'b0}}, last_output}))
    else $error("slot pick out of range");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench: self-checking bench for combined_lcg_shuffle_rng, request and result streams
// predicts every number with its own combined generator and shuffle table, config via seed writes
// depends on clsr_pkg and combined_lcg_shuffle_rng
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_ENTRIES = 32;
  // bucket width that turns the previous number into a shuffle slot
  localparam int unsigned SLOT_DIV = 1 + clsr_pkg::SPAN_MAX / TABLE_ENTRIES;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;     // [0] restart, [7:1] zero
  // result side
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;           // [30:0] random_value, [31] zero
  // seed register channel
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [30:0] cfg_data = 31'd0;  // [30:0] seed_value

  combined_lcg_shuffle_rng #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // generator state mirrored on the bench side
  // ---------------------------------------------------------------------------
  bit [30:0] seed_reg = 31'd1;
  bit [30:0] gen_one = '0;
  bit [30:0] gen_two = '0;
  bit [30:0] prev_value = '0;
  bit [30:0] shuffle_tab [TABLE_ENTRIES];
  bit primed = 1'b0;

  // pending restart flags waiting to go out, and numbers waiting to come back
  bit restart_q [$];
  bit [30:0] expected_values [$];

  // traffic shaping, set between phases from the stimulus process
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit offer;

  // bookkeeping
  int accepted_cnt = 0;
  int restart_cnt = 0;
  int checked_cnt = 0;
  int seed_writes = 0;
  int errors = 0;
  int cycle_count = 0;

  // exact modular multiply, product fits easily in 64 bits
  function automatic bit [30:0] mod_mul(bit [30:0] x, bit [15:0] a, bit [31:0] m);
    bit [63:0] p;
    p = {33'd0, x} * {48'd0, a};
    return 31'(p % {32'd0, m});
  endfunction

  // seed both generators and fill the table; the first 8 steps are thrown away
  function automatic void reseed_table();
    bit [31:0] s;
    s = {1'b0, seed_reg} % clsr_pkg::MOD_ONE;
    if (s == 32'd0) s = 32'd1;
    gen_one = s[30:0];
    gen_two = s[30:0];
    for (int i = TABLE_ENTRIES + 7; i >= 0; i--) begin
      gen_one = mod_mul(gen_one, clsr_pkg::MUL_ONE, clsr_pkg::MOD_ONE);
      if (i < TABLE_ENTRIES) shuffle_tab[i] = gen_one;
    end
    prev_value = shuffle_tab[0];
    primed = 1'b1;
  endfunction

  // one request: advance both generators, swap one table slot, wrap the difference
  function automatic bit [30:0] next_random(bit restart);
    int unsigned slot;
    longint d;
    if (!primed || restart) reseed_table();
    gen_one = mod_mul(gen_one, clsr_pkg::MUL_ONE, clsr_pkg::MOD_ONE);
    gen_two = mod_mul(gen_two, clsr_pkg::MUL_TWO, clsr_pkg::MOD_TWO);
    slot = prev_value / SLOT_DIV;
    // never taken at 32 entries, kept for other table sizes
    if (slot >= TABLE_ENTRIES) slot = TABLE_ENTRIES - 1;
    d = longint'(shuffle_tab[slot]) - longint'(gen_two);
    shuffle_tab[slot] = gen_one;
    if (d < 1) d += longint'(clsr_pkg::SPAN_MAX);
    prev_value = d[30:0];
    return prev_value;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(bit enable);
    int unsigned r;
    if (!enable) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic void note_mismatch(string what, bit [31:0] want, bit [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %0s: expected 0x%08h got 0x%08h", what, want, got);
  endfunction

  // seeds at and around both moduli, plus zero and all ones
  function automatic bit [30:0] edge_seed(int k);
    case (k)
      0: return 31'd0;
      1: return 31'd1;
      2: return 31'd2147483562;
      3: return 31'd2147483563;
      4: return 31'd2147483399;
      5: return 31'd2147483400;
      default: return 31'h7FFF_FFFF;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: peeks the oldest pending flag, pops it once the beat is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        // prediction happens at the accepting edge, against the current seed
        expected_values.push_back(next_random(restart_q[0]));
        if (restart_q[0]) restart_cnt++;
        restart_q.pop_front();
        accepted_cnt <= accepted_cnt + 1;
        offer = 1'b0;
        send_wait = pick_gap(send_idle);
      end
      if (!offer) begin
        if (send_wait != 0) send_wait--;
        else if (restart_q.size() != 0) offer = 1'b1;
      end
      s_tvalid <= offer;
      // garbage on the data lines while nothing is offered
      if (offer) s_tdata <= {7'd0, restart_q[0]};
      else s_tdata <= 8'($urandom_range(255));
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks each beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_values.size() == 0) begin
          note_mismatch("unexpected result", 32'd0, m_tdata);
        end else begin
          if (m_tdata !== {1'b0, expected_values[0]})
            note_mismatch("random_value", {1'b0, expected_values[0]}, m_tdata);
          expected_values.pop_front();
          checked_cnt++;
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_wait = pick_gap(recv_idle);
      end
    end
  end

  // one long receiver hold-off while requests keep coming, backs up into s_tready
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT && restart_q.size() > 4) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_values.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(bit restart);
    restart_q.push_back(restart);
  endtask

  // block idle: nothing queued, nothing offered, nothing owed
  task automatic wait_drained();
    while (restart_q.size() != 0 || s_tvalid || expected_values.size() != 0)
      @(negedge clk);
  endtask

  // only called while the block is idle; every request produces a result,
  // so an empty expectation queue means nothing is in flight
  task automatic write_seed(bit [30:0] value);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_data <= 31'($urandom());
    seed_reg = value;
    seed_writes++;
    @(negedge clk);
  endtask

  initial begin
    int unsigned pct;
    int n;
    int random_sent;
    bit [30:0] seed;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset seed, first request seeds even without restart
    send_idle = 1'b1;
    recv_idle = 1'b1;
    push_req(1'b0);
    push_req(1'b0);
    push_req(1'b0);
    push_req(1'b1);
    push_req(1'b0);
    wait_drained();

    // directed: seed extremes, including zero and values past either modulus;
    // a plain request after the write still follows the old sequence
    for (int k = 0; k < 7; k++) begin
      write_seed(edge_seed(k));
      push_req(1'b0);
      push_req(1'b1);
      wait_drained();
    end

    // random phases, each with its own seed, restart rate and traffic shape
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(5) == 0) seed = edge_seed($urandom_range(6));
      else seed = 31'($urandom());
      write_seed(seed);
      send_idle = ($urandom_range(3) != 0);
      recv_idle = ($urandom_range(3) != 0);
      pct = $urandom_range(20, 2);
      n = $urandom_range(160, 40);
      for (int i = 0; i < n; i++)
        push_req($urandom_range(99) < pct);
      random_sent += n;
      wait_drained();
    end

    // let any stray beat show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_values.size() != 0)
      note_mismatch("missing results", 32'(expected_values.size()), 32'd0);

    $display("run covered %0d requests (%0d reseeding) across %0d seed writes",
             accepted_cnt, restart_cnt, seed_writes);
    $display("%0d numbers checked, %0d mismatches", checked_cnt, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/clsr_pkg.sv
sv/combined_lcg_shuffle_rng.sv
tb/testbench.sv
